/* design/pvc_pkg.sv */
// ----------------------------------------------------------------------------
// pvc_pkg
// Shared types and constants for the printable Vigenere cipher block.
// ----------------------------------------------------------------------------
`default_nettype none

package pvc_pkg;

  // Largest number of key bytes the block is built for by default.
  localparam int unsigned KeyBytesDefault = 8;

  // Configuration port geometry.
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned KeyLenW   = 4;

  // Register values after reset: the key "KEY", three bytes long.
  localparam logic [CfgDataW-1:0] KeyCharsReset  = 64'h0000_0000_0059_454B;
  localparam logic [KeyLenW-1:0]  KeyLengthReset = 4'd3;

  // Printable ASCII window and its size.
  localparam logic [7:0] PrintLo  = 8'd32;
  localparam logic [7:0] PrintHi  = 8'd126;
  localparam logic [7:0] PrintMod = 8'd95;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIndexW-1:0] {
    CFG_KEY_CHARS    = 2'd0,
    CFG_KEY_LENGTH   = 2'd1,
    CFG_DECRYPT_MODE = 2'd2
  } cfg_reg_e;

  // Result of ciphering one character.
  typedef struct packed {
    logic [7:0] char_val;
    logic       bad;
  } cipher_res_t;

endpackage

`default_nettype wire

/* design/pvc_cipher_unit.sv */
// ----------------------------------------------------------------------------
// pvc_cipher_unit
// Modular add or subtract of one key byte over the 95 printable codes.
// ----------------------------------------------------------------------------
`default_nettype none

module pvc_cipher_unit (
  input  wire logic                 decrypt_i,
  input  wire logic [7:0]           char_i,
  input  wire logic [7:0]           key_i,
  output pvc_pkg::cipher_res_t      res_o
);

  logic       bad;
  logic [6:0] cm;
  logic [6:0] ke;
  logic [7:0] sum;
  logic [7:0] enc;
  logic [7:0] dec;
  logic [7:0] mix;

  assign bad = (char_i < pvc_pkg::PrintLo) || (char_i > pvc_pkg::PrintHi);
  assign cm  = 7'(char_i - pvc_pkg::PrintLo);

  // Key byte less 32, reduced into 0..94; any byte value is accepted.
  always_comb begin
    if (key_i < 8'd32) begin
      ke = 7'(key_i + 8'd63);
    end else if (key_i >= 8'd222) begin
      ke = 7'(key_i - 8'd222);
    end else if (key_i >= 8'd127) begin
      ke = 7'(key_i - 8'd127);
    end else begin
      ke = 7'(key_i - 8'd32);
    end
  end

  assign sum = {1'b0, cm} + {1'b0, ke};
  assign enc = (sum >= pvc_pkg::PrintMod) ? sum - pvc_pkg::PrintMod : sum;
  assign dec = (cm >= ke) ? {1'b0, cm} - {1'b0, ke}
                          : {1'b0, cm} + pvc_pkg::PrintMod - {1'b0, ke};
  assign mix = decrypt_i ? dec : enc;

  assign res_o.bad      = bad;
  assign res_o.char_val = bad ? char_i : mix + pvc_pkg::PrintLo;

endmodule

`default_nettype wire

/* design/printable_vigenere_cipher.sv */
// ----------------------------------------------------------------------------
// printable_vigenere_cipher
// Streaming Vigenere cipher over the 95 printable ASCII codes.
// ----------------------------------------------------------------------------
// Usage: characters arrive one per beat on the input channel (char_in_i,
// last_in_i, valid/ready) and leave one per beat on the output channel
// (char_out_o, last_out_o, bad_char_o). Every input beat gives exactly one
// output beat, in order.
// A beat accepted at one edge is presented on the output from the next
// cycle. Throughput is one character per cycle while the receiver does
// not stall; the single result register is the only stage, and the key
// position counter advances in the same cycle as the character is taken.
// The key position starts at byte 0, advances once per character, wraps at
// the key length and returns to 0 after a beat marked last.
// Characters outside 32..126 are passed unchanged with bad_char_o set.
// Reset loads the key "KEY", length 3, encrypt mode, position 0, and empties
// the result register. When the receiver stalls, the result is held and a
// new beat is taken only in the cycle in which the held result leaves.
// Configuration writes are taken at any edge with cfg_we_i high and should
// be made only while no beat is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module printable_vigenere_cipher #(
  parameter int unsigned KEY_BYTES = pvc_pkg::KeyBytesDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration write port.
  input  wire logic                          cfg_we_i,
  input  wire logic [pvc_pkg::CfgIndexW-1:0] cfg_index_i,
  input  wire logic [pvc_pkg::CfgDataW-1:0]  cfg_data_i,
  // Input channel.
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [7:0]                    char_in_i,
  input  wire logic                          last_in_i,
  // Output channel.
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [7:0]                    char_out_o,
  output      logic                          last_out_o,
  output      logic                          bad_char_o
);

  localparam int unsigned KeyW = KEY_BYTES * 8;
  localparam int unsigned PosW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam logic [pvc_pkg::KeyLenW-1:0] MaxLen = pvc_pkg::KeyLenW'(KEY_BYTES);

  // Clamp a written length to 1..KEY_BYTES so the counter compare is simple.
  function automatic logic [pvc_pkg::KeyLenW-1:0] clamp_len(
    input logic [pvc_pkg::KeyLenW-1:0] v
  );
    logic [pvc_pkg::KeyLenW-1:0] r;
    if (v == '0) begin
      r = pvc_pkg::KeyLenW'(1);
    end else if (v > MaxLen) begin
      r = MaxLen;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Configuration registers.
  logic [KEY_BYTES-1:0][7:0]        key_q;
  logic [pvc_pkg::KeyLenW-1:0]      len_q;
  logic                             decrypt_q;

  // Key position and result register.
  logic [PosW-1:0]                  pos_q, pos_d;
  logic                             out_valid_q, out_valid_d;
  logic [7:0]                       char_q;
  logic                             last_q;
  logic                             bad_q;

  logic                             in_fire;
  logic [pvc_pkg::KeyLenW-1:0]      pos_next_ext;
  pvc_pkg::cipher_res_t             res;

  // A held result may leave in the same cycle as the next beat enters.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= pvc_pkg::KeyCharsReset[KeyW-1:0];
      len_q     <= clamp_len(pvc_pkg::KeyLengthReset);
      decrypt_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (pvc_pkg::cfg_reg_e'(cfg_index_i))
        pvc_pkg::CFG_KEY_CHARS:    key_q     <= cfg_data_i[KeyW-1:0];
        pvc_pkg::CFG_KEY_LENGTH:   len_q     <= clamp_len(cfg_data_i[pvc_pkg::KeyLenW-1:0]);
        pvc_pkg::CFG_DECRYPT_MODE: decrypt_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The byte at the current position is used even if the length was
  // lowered below it mid-string; the counter then wraps to zero.
  pvc_cipher_unit u_cipher (
    .decrypt_i (decrypt_q),
    .char_i    (char_in_i),
    .key_i     (key_q[pos_q]),
    .res_o     (res)
  );

  assign pos_next_ext = pvc_pkg::KeyLenW'(pos_q) + pvc_pkg::KeyLenW'(1);

  always_comb begin
    pos_d = pos_q;
    if (in_fire) begin
      if (last_in_i || (pos_next_ext >= len_q)) begin
        pos_d = '0;
      end else begin
        pos_d = pos_next_ext[PosW-1:0];
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      char_q <= res.char_val;
      last_q <= last_in_i;
      bad_q  <= res.bad;
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_out_o  = char_q;
  assign last_out_o  = last_q;
  assign bad_char_o  = bad_q;

  // The stored length always lies within the built key size.
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != '0) && (len_q <= MaxLen))
    else $error("key length register out of range");

  // A string boundary restarts the key at byte 0.
  a_last_resets_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last_in_i) |=> (pos_q == '0))
    else $error("key position not cleared after last beat");

  // A good character always maps onto a printable code.
  a_out_printable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !bad_q) |-> ((char_q >= pvc_pkg::PrintLo) && (char_q <= pvc_pkg::PrintHi)))
    else $error("ciphered character outside printable range");

  // An empty result register never blocks the input.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty result register");

endmodule

`default_nettype wire
